### hw/rtl/mmtm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared types and codes of the matrix multiply block.
// ----------------------------------------------------------------------------
package mmtm_pkg;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [2:0] REG_ROWS_A = 3'd0;
  localparam logic [2:0] REG_COLS_A = 3'd1;
  localparam logic [2:0] REG_ROWS_B = 3'd2;
  localparam logic [2:0] REG_COLS_B = 3'd3;
  localparam logic [2:0] REG_TR_A   = 3'd4;
  localparam logic [2:0] REG_TR_B   = 3'd5;

  localparam int MAX_DIM    = 8;
  localparam int PROD_BITS  = 35;
  localparam int RESULT_CAP = 64;

  // Queued job between front and back.
  typedef struct packed {
    logic [1:0] op;      // ST_OK: compute, ST_MISMATCH or ST_RANGE: error word
  } job_t;

endpackage

### hw/rtl/matrix_multiply_transpose_modes.sv
// ----------------------------------------------------------------------------
// Matrix multiply with transpose modes
// Loads two element stores and streams C = op(A) * op(B) in row-major order.
// ----------------------------------------------------------------------------
// Usage: input words carry kind, row, col and a Q8.8 value. Loads are taken
// one per cycle while in_tready is high and written straight into store A or
// B. A compute word queues a job; the back end reads one element pair per
// cycle and accumulates, drains the product and sum registers, and then
// hands each element of C to the output register.
// A load outside the shape or an inner mismatch gives one error word, which
// passes the job queue and the output register when the back end is free.
// A two-entry job queue sits between front and back; the front stalls when
// it is full, and a load waits until no product is in progress. Results
// leave through an output register, so a stalled receiver holds the back end
// without losing words. Reset empties the queue, sets every shape register
// to 8 and both transpose flags to 0; the stores are undefined until written.
module matrix_multiply_transpose_modes #(
  parameter int ELEM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // kind[1:0], row[4:2], col[7:5], value[23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_row[2:0], out_col[5:3], product[40:6], status[42:41]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import mmtm_pkg::*;
  localparam int AW = $clog2(MAX_DIM*MAX_DIM);

  logic [3:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic       tr_a_r, tr_b_r;
  logic [3:0] ra, ca, rb, cb;
  logic       wa_en, wb_en, q_valid, q_pop;
  logic [AW-1:0] waddr, a_raddr, b_raddr;
  logic [ELEM_BITS-1:0] wdata, a_rdata, b_rdata;
  job_t       q_job;

  function automatic logic [3:0] clampd(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'(MAX_DIM)) return 4'(MAX_DIM);
    return v;
  endfunction

  assign ra = clampd(rows_a_r);
  assign ca = clampd(cols_a_r);
  assign rb = clampd(rows_b_r);
  assign cb = clampd(cols_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= 4'd8; cols_a_r <= 4'd8; rows_b_r <= 4'd8; cols_b_r <= 4'd8;
      tr_a_r <= 1'b0; tr_b_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A: rows_a_r <= cfg_data;
        REG_COLS_A: cols_a_r <= cfg_data;
        REG_ROWS_B: rows_b_r <= cfg_data;
        REG_COLS_B: cols_b_r <= cfg_data;
        REG_TR_A:   tr_a_r <= cfg_data[0];
        REG_TR_B:   tr_b_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mmtm_front #(.ELEM_BITS(ELEM_BITS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .ra, .ca, .rb, .cb, .ta(tr_a_r), .tb(tr_b_r),
    .wa_en, .wb_en, .waddr, .wdata, .q_valid, .q_job, .q_pop
  );

  mmtm_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DIM*MAX_DIM)) u_ram_a (
    .clk, .we(wa_en), .waddr, .wdata, .raddr(a_raddr), .rdata(a_rdata)
  );
  mmtm_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DIM*MAX_DIM)) u_ram_b (
    .clk, .we(wb_en), .waddr, .wdata, .raddr(b_raddr), .rdata(b_rdata)
  );

  logic pop_cmp;

  mmtm_back #(.ELEM_BITS(ELEM_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop(pop_cmp),
    .ra, .ca, .rb, .cb, .ta(tr_a_r), .tb(tr_b_r),
    .a_raddr, .b_raddr, .a_rdata, .b_rdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  // A compute job leaves the queue when its final word is handed out.
  assign q_pop = pop_cmp ||
    (out_tvalid && out_tready && out_tlast && out_tdata[42:41] == ST_OK);
endmodule

### hw/rtl/mmtm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mmtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/mmtm_front.sv
// ----------------------------------------------------------------------------
// Matrix multiply front end
// Accepts words, writes loads into the stores and queues jobs for the back end.
// ----------------------------------------------------------------------------
module mmtm_front #(
  parameter int ELEM_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,
  input  logic [3:0]                   ra,
  input  logic [3:0]                   ca,
  input  logic [3:0]                   rb,
  input  logic [3:0]                   cb,
  input  logic                         ta,
  input  logic                         tb,
  output logic                         wa_en,
  output logic                         wb_en,
  output logic [$clog2(mmtm_pkg::MAX_DIM*mmtm_pkg::MAX_DIM)-1:0] waddr,
  output logic [ELEM_BITS-1:0]         wdata,
  output logic                         q_valid,
  output mmtm_pkg::job_t               q_job,
  input  logic                         q_pop
);
  import mmtm_pkg::*;
  localparam int AW = $clog2(MAX_DIM*MAX_DIM);

  logic [1:0] kind;
  logic [2:0] row, col;
  logic [15:0] val;
  logic       acc;
  logic [3:0] nr, nc, inner_a, inner_b;
  logic       oob;
  logic [AW-1:0] addr_full;
  job_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push;
  job_t       pjob;
  logic       is_load, cmp_pend;

  assign kind = in_tdata[1:0];
  assign row  = in_tdata[4:2];
  assign col  = in_tdata[7:5];
  assign val  = in_tdata[23:8];

  // A load waits while a product is still reading the stores.
  assign is_load  = (kind == KIND_LOAD_A) || (kind == KIND_LOAD_B);
  assign cmp_pend = (cnt_r != 2'd0) && (q_r[rd_r].op == ST_OK);
  assign in_tready = (cnt_r != 2'd2) && !(is_load && cmp_pend);
  assign acc  = in_tvalid && in_tready;

  assign nr = (kind == KIND_LOAD_A) ? ra : rb;
  assign nc = (kind == KIND_LOAD_A) ? ca : cb;
  assign oob = ({1'b0, row} >= nr) || ({1'b0, col} >= nc);
  assign inner_a = ta ? ra : ca;
  assign inner_b = tb ? cb : rb;

  always_comb begin
    addr_full = '0;
    addr_full = AW'(({3'b0, row} * 6'(MAX_DIM)) + {3'b0, col});
  end

  assign waddr = addr_full;
  assign wdata = ELEM_BITS'($signed(val));
  assign wa_en = acc && (kind == KIND_LOAD_A) && !oob;
  assign wb_en = acc && (kind == KIND_LOAD_B) && !oob;

  always_comb begin
    push = 1'b0;
    pjob.op = ST_OK;
    if (acc) begin
      case (kind)
        KIND_LOAD_A, KIND_LOAD_B: begin
          push = oob;
          pjob.op = ST_RANGE;
        end
        KIND_COMPUTE: begin
          push = 1'b1;
          pjob.op = (inner_a != inner_b) ? ST_MISMATCH : ST_OK;
        end
        default: push = 1'b0;
      endcase
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  assign rd_nxt  = rd_r ^ q_pop;
  assign wr_nxt  = wr_r ^ push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= pjob;
    end
  end
endmodule

### hw/rtl/mmtm_back.sv
// ----------------------------------------------------------------------------
// Matrix multiply back end
// Walks the product, one MAC per cycle outside drains and stalls; emits words.
// ----------------------------------------------------------------------------
module mmtm_back #(
  parameter int ELEM_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  mmtm_pkg::job_t               q_job,
  output logic                         q_pop,
  input  logic [3:0]                   ra,
  input  logic [3:0]                   ca,
  input  logic [3:0]                   rb,
  input  logic [3:0]                   cb,
  input  logic                         ta,
  input  logic                         tb,
  output logic [$clog2(mmtm_pkg::MAX_DIM*mmtm_pkg::MAX_DIM)-1:0] a_raddr,
  output logic [$clog2(mmtm_pkg::MAX_DIM*mmtm_pkg::MAX_DIM)-1:0] b_raddr,
  input  logic [ELEM_BITS-1:0]         a_rdata,
  input  logic [ELEM_BITS-1:0]         b_rdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,
  output logic                         out_tlast
);
  import mmtm_pkg::*;
  localparam int AW = $clog2(MAX_DIM*MAX_DIM);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DR1  = 3'd2;
  localparam logic [2:0] S_DR2  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [3:0] i_r, j_r, k_r, m, n, inner;
  logic [6:0] cnt_r;
  logic       v1_r, v2_r;
  logic signed [2*ELEM_BITS-1:0] p_r;
  logic signed [PROD_BITS+8:0]   sum_r;
  logic signed [PROD_BITS-1:0]   sat;
  logic       last_k, fin;
  logic [2:0] orow_r, ocol_r;
  logic [1:0] ost_r;
  logic [PROD_BITS-1:0] oprod_r;
  logic       olast_r, ovalid_r;
  logic [3:0] ai, ak, bj, bk;

  assign m     = ta ? ca : ra;
  assign inner = ta ? ra : ca;
  assign n     = tb ? rb : cb;
  assign last_k = (k_r + 4'd1 == inner);
  assign fin = ((i_r + 4'd1 == m) && (j_r + 4'd1 == n)) || (cnt_r + 7'd1 == 7'(RESULT_CAP));

  assign ai = ta ? k_r : i_r;
  assign ak = ta ? i_r : k_r;
  assign bk = tb ? j_r : k_r;
  assign bj = tb ? k_r : j_r;
  assign a_raddr = AW'(ai * MAX_DIM + ak);
  assign b_raddr = AW'(bk * MAX_DIM + bj);

  always_comb begin
    if (sum_r > $signed({{9{1'b0}}, 1'b0, {(PROD_BITS-1){1'b1}}})) begin
      sat = {1'b0, {(PROD_BITS-1){1'b1}}};
    end else if (sum_r < -$signed({{9{1'b0}}, 1'b1, {(PROD_BITS-1){1'b0}}})) begin
      sat = {1'b1, {(PROD_BITS-1){1'b0}}};
    end else begin
      sat = PROD_BITS'(sum_r);
    end
  end

  assign q_pop = (st_r == S_IDLE) && q_valid && !ovalid_r && (q_job.op != ST_OK);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid && !ovalid_r && q_job.op == ST_OK) st_nxt = S_MAC;
      S_MAC:  if (last_k) st_nxt = S_DR1;
      S_DR1:  st_nxt = S_DR2;
      S_DR2:  st_nxt = S_OUT;
      S_OUT:  if (!ovalid_r) st_nxt = fin ? S_IDLE : S_MAC;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0; cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      v1_r <= (st_r == S_MAC);
      v2_r <= v1_r;
      if (q_pop) begin
        ovalid_r <= 1'b1;
        orow_r <= '0; ocol_r <= '0; oprod_r <= '0;
        ost_r <= q_job.op; olast_r <= 1'b1;
      end
      case (st_r)
        S_IDLE: begin
          i_r <= '0; j_r <= '0; k_r <= '0; cnt_r <= '0;
        end
        S_MAC: k_r <= last_k ? k_r : k_r + 4'd1;
        S_OUT: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          orow_r <= i_r[2:0]; ocol_r <= j_r[2:0];
          oprod_r <= sat; ost_r <= ST_OK; olast_r <= fin;
          k_r <= '0;
          cnt_r <= cnt_r + 7'd1;
          if (j_r + 4'd1 == n) begin
            j_r <= '0; i_r <= i_r + 4'd1;
          end else begin
            j_r <= j_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
    p_r <= $signed(a_rdata) * $signed(b_rdata);
    if (st_r == S_IDLE || (st_r == S_OUT && !ovalid_r)) begin
      sum_r <= '0;
    end else if (v2_r) begin
      sum_r <= sum_r + (PROD_BITS+9)'(p_r);
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'b0, ost_r, oprod_r, ocol_r, orow_r};
endmodule

### hw/rtl/mmtm_checker.sv
// ----------------------------------------------------------------------------
// Matrix multiply port checker
// Watches the top level's ports for handshake and result rules.
// ----------------------------------------------------------------------------
module mmtm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);
  import mmtm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[42:41] != ST_OK |-> out_tlast)
    else $error("error word without last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[42:41] != ST_OK |-> out_tdata[40:0] == 41'd0)
    else $error("error word with payload");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[42:41] != 2'd3)
    else $error("unused status code");
endmodule

bind matrix_multiply_transpose_modes mmtm_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

### tb/matrix_multiply_transpose_modes_test.sv
// ----------------------------------------------------------------------------
// Matrix multiply with transpose modes: testbench
// Fills both element stores, then runs a directed table and random phases of
// loads and products under random transpose and shape settings. Every product
// and error word is checked against an in-bench model or a table entry.
// ----------------------------------------------------------------------------
module matrix_multiply_transpose_modes_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mmtm_pkg::*;

  typedef struct {
    logic [2:0]  orow;
    logic [2:0]  ocol;
    logic [34:0] prod;
    logic [1:0]  stat;
    logic        last;
  } cword_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [3:0]  cdat;
    logic [1:0]  kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] value;
    bit          typed;
    logic [34:0] prod;
    logic [1:0]  stat;
  } step_t;

  localparam int WATCH_LIMIT = 5000;
  localparam int SETTLE      = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;

  logic signed [15:0] mem_a [64];
  logic signed [15:0] mem_b [64];
  logic [3:0] shape [4];
  logic       tr_a, tr_b;
  cword_t     pending [$];
  int         errors, n_words, n_products, n_faults, n_items;
  bit         steady, hold_req;
  int         watch;

  matrix_multiply_transpose_modes u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff(logic [3:0] r);
    if (r == 0) return 1;
    if (r > 8) return 8;
    return r;
  endfunction

  function automatic cword_t fault(logic [1:0] s);
    cword_t w;
    w.orow = 0; w.ocol = 0; w.prod = 0; w.stat = s; w.last = 1'b1;
    return w;
  endfunction

  // Applies one accepted word to the model and queues what it should produce.
  function automatic void model_word(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                                     logic [15:0] value);
    int ra, ca, rb, cb, m, inr, inr_b, n;
    longint acc;
    cword_t w;
    ra = eff(shape[0]); ca = eff(shape[1]); rb = eff(shape[2]); cb = eff(shape[3]);
    if (kind == KIND_LOAD_A || kind == KIND_LOAD_B) begin
      if (kind == KIND_LOAD_A && (row >= ra || col >= ca) ||
          kind == KIND_LOAD_B && (row >= rb || col >= cb)) begin
        pending.push_back(fault(ST_RANGE));
      end else if (kind == KIND_LOAD_A) begin
        mem_a[row * 8 + col] = value;
      end else begin
        mem_b[row * 8 + col] = value;
      end
    end else if (kind == KIND_COMPUTE) begin
      m = tr_a ? ca : ra;
      inr = tr_a ? ra : ca;
      inr_b = tr_b ? cb : rb;
      n = tr_b ? rb : cb;
      if (inr != inr_b) begin
        pending.push_back(fault(ST_MISMATCH));
      end else begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < inr; k++) begin
              acc += longint'(tr_a ? mem_a[k * 8 + i] : mem_a[i * 8 + k]) *
                     longint'(tr_b ? mem_b[j * 8 + k] : mem_b[k * 8 + j]);
            end
            w.orow = 3'(i); w.ocol = 3'(j); w.prod = acc[34:0]; w.stat = ST_OK;
            w.last = (i == m - 1 && j == n - 1);
            pending.push_back(w);
          end
        end
      end
    end
  endfunction

  task automatic send_word(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                           logic [15:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {value, col, row, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_word(kind, row, col, value);
    n_items++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_COLS_B) shape[idx] = val;
    else if (idx == REG_TR_A) tr_a = val[0];
    else if (idx == REG_TR_B) tr_b = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] pick_shape();
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  // Receiver: random stalls, a steady stretch, and one long hold-off.
  initial begin
    int hold;
    out_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || $urandom_range(0, 99) >= 17;
      end
    end
  end

  // Result check at the rising edge.
  always @(posedge clk) begin
    cword_t w;
    if (rst_n && out_tvalid && out_tready) begin
      n_words++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word row %0d col %0d product %0d status %0d last %0b",
                 $time, out_tdata[2:0], out_tdata[5:3], $signed(out_tdata[40:6]),
                 out_tdata[42:41], out_tlast);
        errors++;
      end else begin
        w = pending.pop_front();
        if (w.stat == ST_OK) n_products++;
        else n_faults++;
        if (out_tdata[2:0] !== w.orow || out_tdata[5:3] !== w.ocol ||
            out_tdata[40:6] !== w.prod || out_tdata[42:41] !== w.stat ||
            out_tlast !== w.last) begin
          $display("%0t: mismatch expected row %0d col %0d product %0d status %0d last %0b",
                   $time, w.orow, w.ocol, $signed(w.prod), w.stat, w.last);
          $display("%0t:          actual   row %0d col %0d product %0d status %0d last %0b",
                   $time, out_tdata[2:0], out_tdata[5:3], $signed(out_tdata[40:6]),
                   out_tdata[42:41], out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      watch <= 0;
    end else begin
      watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
        $display("%0t: no progress, %0d words outstanding", $time, pending.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  step_t plan [$];

  task automatic add_cfg(logic [2:0] idx, logic [3:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1; s.idx = idx; s.cdat = val;
    plan.push_back(s);
  endtask

  task automatic add_word(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                          logic [15:0] value, bit typed, logic [34:0] prod,
                          logic [1:0] stat);
    step_t s;
    s = '{default: '0};
    s.kind = kind; s.row = row; s.col = col; s.value = value;
    s.typed = typed; s.prod = prod; s.stat = stat;
    plan.push_back(s);
  endtask

  initial begin
    int ra, ca, inr;
    logic [1:0] kind;
    logic [2:0] r, c;
    bit mixed;
    cword_t w;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; n_words = 0; n_products = 0; n_faults = 0; n_items = 0;
    steady = 1'b0; hold_req = 1'b0;
    shape[0] = 8; shape[1] = 8; shape[2] = 8; shape[3] = 8; tr_a = 0; tr_b = 0;
    for (int i = 0; i < 64; i++) begin
      mem_a[i] = 0; mem_b[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every element of both stores is written before any product reads it.
    for (int i = 0; i < 64; i++) begin
      send_word(KIND_LOAD_A, 3'(i / 8), 3'(i % 8), 16'($urandom));
      send_word(KIND_LOAD_B, 3'(i / 8), 3'(i % 8), 16'($urandom));
    end
    add_word(KIND_COMPUTE, 0, 0, 0, 0, 0, 0);
    add_cfg(REG_ROWS_A, 1); add_cfg(REG_COLS_A, 1);
    add_cfg(REG_ROWS_B, 1); add_cfg(REG_COLS_B, 1);
    add_word(KIND_LOAD_A, 0, 0, 16'h7fff, 0, 0, 0);
    add_word(KIND_LOAD_B, 0, 0, 16'h8000, 0, 0, 0);
    add_word(KIND_COMPUTE, 7, 7, 16'hffff, 1, -35'sd1073709056, ST_OK);
    add_word(KIND_LOAD_A, 1, 0, 16'h1234, 1, 0, ST_RANGE);
    add_word(KIND_LOAD_B, 0, 7, 16'hffff, 1, 0, ST_RANGE);
    add_word(2'd3, 7, 7, 16'hffff, 0, 0, 0);
    add_cfg(REG_COLS_A, 2);
    add_word(KIND_COMPUTE, 0, 0, 0, 1, 0, ST_MISMATCH);
    add_cfg(REG_COLS_A, 0);
    add_word(KIND_COMPUTE, 0, 0, 0, 0, 0, 0);
    add_cfg(REG_ROWS_A, 15); add_cfg(REG_COLS_A, 8);
    add_cfg(REG_ROWS_B, 8); add_cfg(REG_COLS_B, 8);
    add_word(KIND_COMPUTE, 0, 0, 0, 0, 0, 0);
    add_cfg(REG_TR_A, 1); add_cfg(REG_TR_B, 1);
    add_word(KIND_COMPUTE, 0, 0, 0, 0, 0, 0);
    add_cfg(REG_COLS_B, 3);
    add_word(KIND_COMPUTE, 0, 0, 0, 1, 0, ST_MISMATCH);

    foreach (plan[p]) begin
      if (plan[p].is_cfg) begin
        drain();
        write_reg(plan[p].idx, plan[p].cdat);
      end else begin
        send_word(plan[p].kind, plan[p].row, plan[p].col, plan[p].value);
        if (plan[p].typed) begin
          void'(pending.pop_back());
          w = fault(plan[p].stat);
          w.prod = plan[p].prod;
          pending.push_back(w);
        end
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(REG_TR_A, 4'($urandom_range(0, 1)));
      write_reg(REG_TR_B, 4'($urandom_range(0, 1)));
      write_reg(REG_ROWS_A, pick_shape());
      write_reg(REG_COLS_A, pick_shape());
      inr = tr_a ? eff(shape[0]) : eff(shape[1]);
      mixed = $urandom_range(0, 99) < 20;
      if (tr_b) begin
        write_reg(REG_ROWS_B, pick_shape());
        write_reg(REG_COLS_B, mixed ? pick_shape() : 4'(inr));
      end else begin
        write_reg(REG_COLS_B, pick_shape());
        write_reg(REG_ROWS_B, mixed ? pick_shape() : 4'(inr));
      end
      steady = (ph == 4);
      if (ph == 7) hold_req = 1'b1;
      for (int it = 0; it < 22; it++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: kind = KIND_COMPUTE;
          3:       kind = 2'd3;
          default: kind = $urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A;
        endcase
        if (ph == 7 && it < 6) kind = KIND_COMPUTE;
        ra = eff(shape[kind == KIND_LOAD_B ? 2 : 0]);
        ca = eff(shape[kind == KIND_LOAD_B ? 3 : 1]);
        if ($urandom_range(0, 9) == 0) begin
          r = 3'($urandom); c = 3'($urandom);
        end else begin
          r = 3'($urandom_range(0, ra - 1)); c = 3'($urandom_range(0, ca - 1));
        end
        send_word(kind, r, c, 16'($urandom));
      end
      steady = 1'b0;
    end

    drain();
    $display("Covered %0d input words: %0d product elements, %0d error words checked.",
             n_items, n_products, n_faults);
    $display("All transpose modes, shape extremes and a long receiver stall were exercised.");
    if (errors == 0 && pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
